>>> sv/chained_hash_multimap_assert.svh
// Assertion macros shared by the hash multimap RTL.
// No dependencies.
`ifndef CHAINED_HASH_MULTIMAP_ASSERT_SVH
`define CHAINED_HASH_MULTIMAP_ASSERT_SVH
// Implication checked on every clock, off during reset.
`define CHM_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CHM_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> sv/chm_pkg.sv
// Package for the hash multimap: sizes, kind codes, state encoding.
// No dependencies.
package chm_pkg;
    localparam int BUCKET_COUNT = 64;
    localparam int POOL_SIZE    = 256;
    localparam int MAX_OUT      = 63;
    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int NW = $clog2(POOL_SIZE);
    localparam int LW = NW + 1;
    localparam int CW = 9;
    localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);
    localparam logic [CW-1:0] COUNT_MAX = '1;

    localparam logic [1:0] K_INSERT = 2'd0;
    localparam logic [1:0] K_LOOKUP = 2'd1;
    localparam logic [1:0] K_ERASE  = 2'd2;
    localparam logic [1:0] K_IGNORE = 2'd3;

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HEAD  = 9'b000000100,
        S_INS   = 9'b000001000,
        S_RD    = 9'b000010000,
        S_CHK   = 9'b000100000,
        S_EMIT  = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_WAIT  = 9'b100000000
    } t_state;
endpackage

>>> sv/chained_hash_multimap.sv
// Hash multimap over a node pool with chained buckets; top level.
// Uses chm_pkg, chm_ram and the assertion macro header.
// After reset a clearing pass over all POOL_SIZE (256) nodes builds the free list
// and empties the buckets; no word is accepted then. An insert steps through
// S_HEAD, S_INS and S_WAIT before the next word is taken (S_HEAD and S_WAIT only
// when the pool is full or the kind is unknown); a lookup or erase steps through
// S_HEAD, S_RD and S_CHK per chain node walked, S_EMIT per value emitted and S_FIN,
// as the node memories have a registered read; a stalled output adds its wait. Results
// leave through an output register; one word is accepted at a time. Bucket is key mod 64.
`include "chained_hash_multimap_assert.svh"
module chained_hash_multimap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // key[31:0], item_value[63:32], max_values[69:64]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // found_value[31:0], match_count[40:32], status[41]
    output logic        m_axis_tlast
);
    localparam int BW = chm_pkg::BW;
    localparam int NW = chm_pkg::NW;
    localparam int LW = chm_pkg::LW;
    localparam int CW = chm_pkg::CW;

    chm_pkg::t_state r_st, n_st;
    logic [1:0]    r_kind;
    logic [31:0]   r_key, r_val;
    logic [5:0]    r_lim;
    logic [LW-1:0] r_free, r_cur, r_prev;
    logic [CW-1:0] r_cnt;
    logic [8:0]    r_steps;
    logic [NW:0]   r_init;
    logic [5:0]    r_emitted;

    logic          r_ov;
    logic [31:0]   r_ofv;
    logic [CW-1:0] r_ocnt;
    logic          r_ost, r_olast;

    // memories
    logic          key_we, val_we, lnk_we, hd_we, sz_we;
    logic [NW-1:0] key_wa, lnk_wa, nd_ra;
    logic [LW-1:0] lnk_wd, hd_wd;
    logic [BW-1:0] hd_wa, hd_ra;
    logic [8:0]    sz_wd, sz_rd;
    logic [31:0]   key_rd, val_rd;
    logic [LW-1:0] lnk_rd, hd_rd;
    logic [BW-1:0] r_b;

    // prev-link fix for erase uses a second write cycle slot: done in S_RD
    logic          fix_we;
    logic          r_fix;
    logic [LW-1:0] r_fixd;
    logic [NW-1:0] r_fixa;

    // merged link-write: fix wins in S_RD, where the main path never writes
    logic          lw_e;
    logic [NW-1:0] lw_a;
    logic [LW-1:0] lw_d;

    chm_ram #(.WIDTH(32), .DEPTH(chm_pkg::POOL_SIZE)) u_key (
        .i_clk, .i_we(key_we), .i_waddr(key_wa), .i_wdata(r_key),
        .i_raddr(nd_ra), .o_rdata(key_rd));
    chm_ram #(.WIDTH(32), .DEPTH(chm_pkg::POOL_SIZE)) u_val (
        .i_clk, .i_we(val_we), .i_waddr(key_wa), .i_wdata(r_val),
        .i_raddr(nd_ra), .o_rdata(val_rd));
    chm_ram #(.WIDTH(LW), .DEPTH(chm_pkg::POOL_SIZE)) u_lnk (
        .i_clk, .i_we(lw_e), .i_waddr(lw_a), .i_wdata(lw_d),
        .i_raddr(nd_ra), .o_rdata(lnk_rd));
    chm_ram #(.WIDTH(LW), .DEPTH(chm_pkg::BUCKET_COUNT)) u_hd (
        .i_clk, .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(hd_ra), .o_rdata(hd_rd));
    chm_ram #(.WIDTH(9), .DEPTH(chm_pkg::BUCKET_COUNT)) u_sz (
        .i_clk, .i_we(sz_we), .i_waddr(hd_wa), .i_wdata(sz_wd),
        .i_raddr(hd_ra), .o_rdata(sz_rd));

    logic out_free;
    logic acc;
    logic match;
    logic [5:0] lim_c;
    assign out_free = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_st == chm_pkg::S_IDLE) && out_free;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign match = (key_rd == r_key);
    assign lim_c = (r_lim > 6'(chm_pkg::MAX_OUT)) ? 6'(chm_pkg::MAX_OUT) : r_lim;
    assign hd_ra = acc ? s_axis_tdata[BW-1:0] : r_b;
    // free node's link is fetched while the bucket head is being read
    assign nd_ra = (r_st == chm_pkg::S_HEAD) ? r_free[NW-1:0] : r_cur[NW-1:0];

    logic          emit_v, emit_l, emit_s;
    logic [31:0]   emit_f;
    logic [CW-1:0] emit_c;

    always_comb begin
        n_st = r_st;
        key_we = 1'b0; val_we = 1'b0; lnk_we = 1'b0; hd_we = 1'b0; sz_we = 1'b0;
        key_wa = r_free[NW-1:0];
        lnk_wa = r_free[NW-1:0];
        lnk_wd = hd_rd;
        hd_wa = r_b;
        hd_wd = r_free;
        sz_wd = sz_rd + 9'd1;
        emit_v = 1'b0; emit_l = 1'b1; emit_s = 1'b0;
        emit_f = '0; emit_c = '0;
        case (r_st)
            chm_pkg::S_INIT: begin
                lnk_we = 1'b1;
                lnk_wa = r_init[NW-1:0];
                lnk_wd = LW'(r_init) + LW'(1);
                hd_we = (r_init < (NW+1)'(chm_pkg::BUCKET_COUNT));
                hd_wa = r_init[BW-1:0];
                hd_wd = chm_pkg::NIL;
                sz_we = hd_we;
                sz_wd = '0;
                if (r_init == (NW+1)'(chm_pkg::POOL_SIZE - 1)) begin
                    n_st = chm_pkg::S_IDLE;
                end
            end
            chm_pkg::S_IDLE: begin
                if (acc) begin
                    n_st = chm_pkg::S_HEAD;
                end
            end
            chm_pkg::S_HEAD: begin
                if (r_kind == chm_pkg::K_INSERT) begin
                    if (r_free == chm_pkg::NIL) begin
                        emit_v = 1'b1; emit_s = 1'b1;
                        n_st = chm_pkg::S_WAIT;
                    end else begin
                        n_st = chm_pkg::S_INS;
                    end
                end else if (r_kind inside {chm_pkg::K_LOOKUP, chm_pkg::K_ERASE}) begin
                    n_st = chm_pkg::S_RD;
                end else begin
                    emit_v = 1'b1;
                    n_st = chm_pkg::S_WAIT;
                end
            end
            chm_pkg::S_INS: begin
                key_we = 1'b1; val_we = 1'b1; lnk_we = 1'b1;
                hd_we = 1'b1; sz_we = 1'b1;
                emit_v = 1'b1;
                n_st = chm_pkg::S_WAIT;
            end
            chm_pkg::S_RD: begin
                if (r_cur >= chm_pkg::NIL || r_steps == 9'(chm_pkg::POOL_SIZE)) begin
                    n_st = chm_pkg::S_FIN;
                end else begin
                    n_st = chm_pkg::S_CHK;
                end
            end
            chm_pkg::S_CHK: begin
                if (match && r_kind == chm_pkg::K_LOOKUP && r_emitted < lim_c) begin
                    n_st = chm_pkg::S_EMIT;
                end else begin
                    n_st = chm_pkg::S_RD;
                end
                if (match && r_kind == chm_pkg::K_ERASE) begin
                    lnk_we = 1'b1;
                    lnk_wa = r_cur[NW-1:0];
                    lnk_wd = r_free;
                    if (r_prev == chm_pkg::NIL) begin
                        hd_we = 1'b1;
                        hd_wd = lnk_rd;
                    end else begin
                        lnk_we = 1'b1;
                    end
                    sz_we = (sz_rd != '0);
                    sz_wd = sz_rd - 9'd1;
                end
            end
            chm_pkg::S_EMIT: begin
                if (out_free) begin
                    emit_v = 1'b1; emit_l = 1'b0; emit_f = r_val;
                    n_st = chm_pkg::S_RD;
                end
            end
            chm_pkg::S_FIN: begin
                if (out_free) begin
                    emit_v = 1'b1; emit_c = r_cnt;
                    n_st = chm_pkg::S_IDLE;
                end
            end
            chm_pkg::S_WAIT: begin
                n_st = chm_pkg::S_IDLE;
            end
            default: n_st = chm_pkg::S_IDLE;
        endcase
    end

    assign fix_we = r_fix && (r_st == chm_pkg::S_RD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= chm_pkg::S_INIT;
            r_init <= '0;
            r_free <= '0;
            r_ov <= 1'b0;
            r_fix <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == chm_pkg::S_INIT) begin
                r_init <= r_init + 1'b1;
            end
            if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (emit_v) begin
                r_ov <= 1'b1;
                r_ofv <= emit_f;
                r_ocnt <= emit_c;
                r_ost <= emit_s;
                r_olast <= emit_l;
            end
            if (acc) begin
                r_kind <= s_axis_tuser;
                r_key <= s_axis_tdata[31:0];
                r_val <= s_axis_tdata[63:32];
                r_lim <= s_axis_tdata[69:64];
                r_b <= s_axis_tdata[BW-1:0];
                r_cnt <= '0;
                r_steps <= '0;
                r_emitted <= '0;
                r_prev <= chm_pkg::NIL;
                r_fix <= 1'b0;
            end
            if (r_st == chm_pkg::S_HEAD) begin
                r_cur <= hd_rd;
            end
            if (r_st == chm_pkg::S_INS) begin
                r_free <= lnk_rd;
            end
            if (r_st == chm_pkg::S_RD) begin
                r_fix <= 1'b0;
            end
            if (r_st == chm_pkg::S_CHK) begin
                r_steps <= r_steps + 9'd1;
                r_cur <= lnk_rd;
                if (match) begin
                    if (r_cnt != chm_pkg::COUNT_MAX) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_kind == chm_pkg::K_LOOKUP) begin
                        r_val <= val_rd;
                    end
                    if (r_kind == chm_pkg::K_ERASE) begin
                        r_free <= r_cur;
                        if (r_prev != chm_pkg::NIL) begin
                            r_fix <= 1'b1;
                            r_fixa <= r_prev[NW-1:0];
                            r_fixd <= lnk_rd;
                        end
                    end
                end else begin
                    r_prev <= r_cur;
                end
            end
            if (r_st == chm_pkg::S_EMIT && out_free) begin
                r_emitted <= r_emitted + 6'd1;
            end
        end
    end

    assign lw_e = fix_we || lnk_we;
    assign lw_a = fix_we ? r_fixa : lnk_wa;
    assign lw_d = fix_we ? r_fixd : lnk_wd;

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast = r_olast;
    assign m_axis_tdata = {6'd0, r_ost, r_ocnt, r_ofv};

    logic ins_full;
    assign ins_full = (r_st == chm_pkg::S_HEAD) && (r_kind == chm_pkg::K_INSERT)
                      && (r_free == chm_pkg::NIL);

    `CHM_ASSERT_IMP(a_one_owner, r_ov && !m_axis_tready, !emit_v)
    `CHM_ASSERT_IMP(a_no_acc_busy, r_st != chm_pkg::S_IDLE, !s_axis_tready)
    `CHM_ASSERT_NXT(a_ins_full, ins_full, r_ov && m_axis_tdata[41])
    `CHM_ASSERT_IMP(a_fix_slot, fix_we, !(lnk_we && r_st == chm_pkg::S_CHK))
endmodule

>>> sv/chm_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> tb/tb_chained_hash_multimap.sv
// Testbench for chained_hash_multimap: directed and random inserts, lookups and erases on a stream bus.
// Depends on chm_pkg and the RTL; expected words come from a behavioral multimap model.
`timescale 1ns / 100ps

class chm_scoreboard;
    logic [31:0] node_key_q[256];
    logic [31:0] node_val_q[256];
    int unsigned node_next[256];
    int unsigned head_of[64];
    int unsigned free_node;
    logic [42:0] pending[$]; // {last, status, count, value}
    int errors;

    function new();
        for (int i = 0; i < 256; i++) node_next[i] = i + 1;
        for (int i = 0; i < 64; i++) head_of[i] = 256;
        free_node = 0;
        errors = 0;
    endfunction

    function void push_word(logic [31:0] v, int unsigned c, bit st, bit lst);
        logic [8:0] cs;
        cs = (c > 511) ? 9'd511 : 9'(c);
        pending.push_back({lst, st, cs, v});
    endfunction

    function void note_word(logic [1:0] kind, logic [31:0] key, logic [31:0] v,
                            logic [5:0] lim);
        int unsigned b, n, nxt, prev, cnt, emitted, steps;
        b = key % 64;
        cnt = 0;
        emitted = 0;
        if (kind == chm_pkg::K_INSERT) begin
            n = free_node;
            if (n >= 256) begin
                push_word(0, 0, 1, 1);
                return;
            end
            free_node = node_next[n];
            node_key_q[n] = key;
            node_val_q[n] = v;
            node_next[n] = head_of[b];
            head_of[b] = n;
            push_word(0, 0, 0, 1);
        end else if (kind == chm_pkg::K_LOOKUP) begin
            n = head_of[b];
            for (steps = 0; n < 256 && steps < 256; steps++) begin
                if (node_key_q[n] == key) begin
                    if (emitted < lim) begin
                        push_word(node_val_q[n], 0, 0, 0);
                        emitted++;
                    end
                    cnt++;
                end
                n = node_next[n];
            end
            push_word(0, cnt, 0, 1);
        end else if (kind == chm_pkg::K_ERASE) begin
            prev = 256;
            n = head_of[b];
            for (steps = 0; n < 256 && steps < 256; steps++) begin
                nxt = node_next[n];
                if (node_key_q[n] == key) begin
                    if (prev == 256) head_of[b] = nxt;
                    else node_next[prev] = nxt;
                    node_next[n] = free_node;
                    free_node = n;
                    cnt++;
                end else begin
                    prev = n;
                end
                n = nxt;
            end
            push_word(0, cnt, 0, 1);
        end else begin
            push_word(0, 0, 0, 1);
        end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task check_word(logic [47:0] data, bit lst);
        logic [42:0] w;
        if (pending.size() == 0) begin
            report("unexpected word", data[31:0], 0);
            return;
        end
        w = pending.pop_front();
        if (data[31:0] !== w[31:0]) report("found_value", data[31:0], w[31:0]);
        if (data[40:32] !== w[40:32])
            report("match_count", 32'(data[40:32]), 32'(w[40:32]));
        if (data[41] !== w[41]) report("status", 32'(data[41]), 32'(w[41]));
        if (data[47:42] !== 6'd0) report("pad", 32'(data[47:42]), 0);
        if (lst !== w[42]) report("last", 32'(lst), 32'(w[42]));
    endtask
endclass

module tb_chained_hash_multimap;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;  // key, item_value, max_values
    logic [1:0]  s_axis_tuser = '0;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // found_value, match_count, status
    logic        m_axis_tlast;

    chm_scoreboard sb = new();
    int idle_cycles = 0;
    bit stalls_on = 1'b1;
    logic [31:0] keys_used[8];

    chained_hash_multimap i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // sink: random stall per word, with stall-free stretches
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            gap = stalls_on ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_word(m_axis_tdata, m_axis_tlast);
        end
    end

    task send_word(logic [1:0] kind, logic [31:0] key, logic [31:0] v, logic [5:0] lim);
        int gap;
        gap = stalls_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {2'b00, lim, v, key};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(kind, key, v, lim);
    endtask

    function logic [31:0] pick_key();
        return ($urandom_range(0, 3) == 0) ? $urandom() : keys_used[$urandom_range(0, 7)];
    endfunction

    initial begin
        int r;
        logic [1:0] kind;
        for (int i = 0; i < 8; i++) keys_used[i] = $urandom_range(0, 7) * 64 + i % 3;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, all kinds, no match, limit, unknown kind, full pool
        send_word(chm_pkg::K_LOOKUP, 32'h0, 0, 6'd63);
        send_word(chm_pkg::K_ERASE, 32'hFFFF_FFFF, 0, 0);
        send_word(chm_pkg::K_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        send_word(chm_pkg::K_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 0);
        send_word(chm_pkg::K_INSERT, 32'h0000_003F, 32'hFFFF_FFFF, 0);
        send_word(chm_pkg::K_INSERT, 32'h0, 32'h0, 0);
        send_word(chm_pkg::K_INSERT, 32'h40, 32'h1234_5678, 0);
        send_word(chm_pkg::K_LOOKUP, 32'hFFFF_FFFF, 0, 6'd63);
        send_word(chm_pkg::K_LOOKUP, 32'hFFFF_FFFF, 0, 6'd1);
        send_word(chm_pkg::K_LOOKUP, 32'hFFFF_FFFF, 0, 6'd0);
        send_word(chm_pkg::K_LOOKUP, 32'h0, 0, 6'd2);
        send_word(chm_pkg::K_IGNORE, 32'hAAAA_5555, 32'h5555_AAAA, 6'h2A);
        send_word(chm_pkg::K_ERASE, 32'hFFFF_FFFF, 0, 6'h15);
        send_word(chm_pkg::K_ERASE, 32'h40, 0, 0);
        send_word(chm_pkg::K_LOOKUP, 32'h3F, 0, 6'd63);
        // fill the pool from one bucket, overflow, read back, then drain
        stalls_on = 1'b0;
        for (int i = 0; i < 258; i++)
            send_word(chm_pkg::K_INSERT, 32'h5 + 64 * (i % 3), $urandom(), 0);
        send_word(chm_pkg::K_LOOKUP, 32'h5, 0, 6'd63);
        send_word(chm_pkg::K_LOOKUP, 32'h45, 0, 6'd10);
        for (int i = 0; i < 3; i++) send_word(chm_pkg::K_ERASE, 32'h5 + 64 * i, 0, 0);
        send_word(chm_pkg::K_ERASE, 32'hFFFF_FFFF, 0, 0);
        send_word(chm_pkg::K_ERASE, 32'h3F, 0, 0);
        send_word(chm_pkg::K_ERASE, 32'h0, 0, 0);
        stalls_on = 1'b1;

        // random mix over a small key set so chains build up
        for (int i = 0; i < 24; i++) begin
            if (i % 12 == 6) stalls_on = 1'b0;
            if (i % 12 == 9) stalls_on = 1'b1;
            r = $urandom_range(0, 99);
            kind = (r < 50) ? chm_pkg::K_INSERT : (r < 80) ? chm_pkg::K_LOOKUP :
                   (r < 97) ? chm_pkg::K_ERASE : chm_pkg::K_IGNORE;
            send_word(kind, pick_key(), $urandom(), 6'($urandom()));
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && !m_axis_tvalid)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/chm_pkg.sv
sv/chm_ram.sv
sv/chained_hash_multimap.sv
tb/tb_chained_hash_multimap.sv
